@@ hdl/pmx_permutation_crossover_top_defines.svh @@
// assertion macros for the pmx crossover block
`ifndef PMX_PERMUTATION_CROSSOVER_TOP_DEFINES_SVH
`define PMX_PERMUTATION_CROSSOVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PMX_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pmx assertion failed");
`define PMX_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pmx assertion failed");
`else
`define PMX_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define PMX_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

@@ hdl/pmx_pkg.sv @@
// shared types and constants of the pmx crossover block
package pmx_pkg;

  localparam int TOUR_LEN_MAX_DEF = 32;
  localparam int CITY_BITS_DEF    = 5;
  localparam int CUT_BITS         = 6;

  typedef enum logic [8:0] {
    S_LOAD     = 9'b000000001,
    S_SETUP    = 9'b000000010,
    S_SCAN_RD  = 9'b000000100,
    S_SCAN_ACC = 9'b000001000,
    S_CHECK    = 9'b000010000,
    S_OUT_RD   = 9'b000100000,
    S_OUT_LD   = 9'b001000000,
    S_CHAIN    = 9'b010000000,
    S_EMIT     = 9'b100000000
  } pmx_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic setup;
    logic scan_acc;
    logic check;
    logic city_ld;
    logic step;
    logic emit;
  } pmx_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic chain_done;
    logic out_free;
  } pmx_sts_t;

endpackage

@@ hdl/pmx_ctrl.sv @@
// sequencing state machine of the pmx crossover block
module pmx_ctrl import pmx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output pmx_cmd_t cmd,
  input  pmx_sts_t sts
);

  pmx_state_t state, state_next;

  assign in_ready = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start  = 1'b1;
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_ACC;
      end
      S_SCAN_ACC: begin
        cmd.scan_acc = 1'b1;
        state_next   = sts.idx_last ? S_CHECK : S_SCAN_RD;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_OUT_RD;
      end
      S_OUT_RD: begin
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.city_ld = 1'b1;
        state_next  = S_CHAIN;
      end
      S_CHAIN: begin
        if (sts.chain_done) begin
          state_next = S_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.idx_last ? S_LOAD : S_OUT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

@@ hdl/pmx_datapath.sv @@
// parent stores, segment maps, chain follower and output register
`include "pmx_permutation_crossover_top_defines.svh"

module pmx_datapath import pmx_pkg::*; #(
  parameter int TOUR_LEN_MAX = TOUR_LEN_MAX_DEF,
  parameter int CITY_BITS    = CITY_BITS_DEF,
  localparam int IDX_W       = $clog2(TOUR_LEN_MAX)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CITY_BITS-1:0] gene_a,
  input  logic [CITY_BITS-1:0] gene_b,
  input  logic [CUT_BITS-1:0]  cut_left,
  input  logic [CUT_BITS-1:0]  cut_right,
  input  pmx_cmd_t             cmd,
  output pmx_sts_t             sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [IDX_W-1:0]     position,
  output logic [CITY_BITS-1:0] child_a,
  output logic [CITY_BITS-1:0] child_b,
  output logic                 bad_parents,
  output logic                 last_out
);

  localparam int NUM_CITIES = 1 << CITY_BITS;
  localparam int CNT_W      = $clog2(TOUR_LEN_MAX + 1);
  localparam int CMP_W      = (CUT_BITS > CNT_W) ? CUT_BITS : CNT_W;

  logic [CITY_BITS-1:0] mem_a [TOUR_LEN_MAX];
  logic [CITY_BITS-1:0] mem_b [TOUR_LEN_MAX];
  logic [CITY_BITS-1:0] map_a [NUM_CITIES];
  logic [CITY_BITS-1:0] map_b [NUM_CITIES];

  logic [CNT_W-1:0]      count, n, lo, hi, steps;
  logic [CUT_BITS-1:0]   cut_l_q, cut_r_q;
  logic [IDX_W-1:0]      idx;
  logic [CITY_BITS-1:0]  rd_a, rd_b, city_a, city_b;
  logic [NUM_CITIES-1:0] set_a, set_b, valid_a, valid_b;
  logic                  bad, in_seg_q;

  logic             room, in_seg, idx_last;
  logic [CNT_W-1:0] idx_x;
  logic [CMP_W-1:0] cl_x, cr_x, n_x, lo_x, hi_x;

  assign room     = count < CNT_W'(TOUR_LEN_MAX);
  assign idx_x    = CNT_W'(idx);
  assign idx_last = (idx_x + CNT_W'(1)) == n;
  assign in_seg   = (idx_x >= lo) && (idx_x <= hi);

  // cut ordering and clamp to tour length
  assign cl_x = CMP_W'(cut_l_q);
  assign cr_x = CMP_W'(cut_r_q);
  assign n_x  = CMP_W'(n);
  assign lo_x = (cl_x < cr_x) ? cl_x : cr_x;
  assign hi_x = (cl_x < cr_x) ? cr_x : cl_x;

  assign sts.idx_last   = idx_last;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.chain_done = in_seg_q || bad || (steps == n) ||
                          (!valid_a[city_a] && !valid_b[city_b]);

  // parent stores
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem_a[count[IDX_W-1:0]] <= gene_a;
      mem_b[count[IDX_W-1:0]] <= gene_b;
    end
    rd_a <= mem_a[idx];
    rd_b <= mem_b[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      valid_a   <= '0;
      valid_b   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (cmd.start) begin
          count <= '0;
        end else if (room) begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.setup) begin
        valid_a <= '0;
        valid_b <= '0;
      end else if (cmd.scan_acc && in_seg) begin
        valid_a[rd_b] <= 1'b1;
        valid_b[rd_a] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cut_l_q <= cut_left;
      cut_r_q <= cut_right;
      n       <= room ? count + CNT_W'(1) : count;
    end
    if (cmd.setup) begin
      lo    <= (lo_x > n_x) ? n : CNT_W'(lo_x);
      hi    <= (hi_x > n_x) ? n : CNT_W'(hi_x);
      set_a <= '0;
      set_b <= '0;
      bad   <= 1'b0;
      idx   <= '0;
    end else if (cmd.scan_acc) begin
      // duplicate check and first-occurrence segment mapping
      if (set_a[rd_a] || set_b[rd_b]) begin
        bad <= 1'b1;
      end
      set_a[rd_a] <= 1'b1;
      set_b[rd_b] <= 1'b1;
      if (in_seg) begin
        if (!valid_a[rd_b]) begin
          map_a[rd_b] <= rd_a;
        end
        if (!valid_b[rd_a]) begin
          map_b[rd_a] <= rd_b;
        end
      end
      idx <= idx + IDX_W'(1);
    end else if (cmd.check) begin
      if (set_a != set_b) begin
        bad <= 1'b1;
      end
      idx <= '0;
    end else if (cmd.emit) begin
      idx <= idx + IDX_W'(1);
    end

    if (cmd.city_ld) begin
      // segment positions take the other parent
      city_a   <= in_seg ? rd_b : rd_a;
      city_b   <= in_seg ? rd_a : rd_b;
      in_seg_q <= in_seg;
      steps    <= '0;
    end else if (cmd.step) begin
      if (valid_a[city_a]) begin
        city_a <= map_a[city_a];
      end
      if (valid_b[city_b]) begin
        city_b <= map_b[city_b];
      end
      steps <= steps + CNT_W'(1);
    end

    if (cmd.emit) begin
      position    <= idx;
      child_a     <= bad ? '0 : city_a;
      child_b     <= bad ? '0 : city_b;
      bad_parents <= bad;
      last_out    <= idx_last;
    end
  end

  `PMX_ASSERT_IMP(a_step_bound, clk, rst, cmd.step, steps < n)
  `PMX_ASSERT_IMP(a_idx_range, clk, rst, cmd.scan_acc || cmd.city_ld, idx_x < n)
  `PMX_ASSERT_IMP(a_bad_zero, clk, rst, out_valid && bad_parents,
                  child_a == '0 && child_b == '0)
  `PMX_ASSERT_NXT(a_last_mark, clk, rst, cmd.emit && idx_last, out_valid && last_out)

endmodule

@@ hdl/pmx_permutation_crossover_top.sv @@
// top level of the pmx crossover block
//
// input channel: one request per tour position, carrying the city of each parent
// (gene_a, gene_b); the request with last high closes the tour and brings the two
// cut points, which may come in either order and are clamped to the tour length.
// positions beyond TOUR_LEN_MAX are dropped.
// loading accepts one position per cycle. after the last request the block stops
// taking input and works on the tour: a setup step, a read and an accumulate step
// per position for the permutation check and segment mapping, a step to finish the
// check, then per position a read, a load, one chain step per link of the mapping
// chain (at most the tour length) in the chain follower, and an emit step.
// output channel: one result per position, in order, with last_out on the final
// one; bad_parents set and children zero when the parents are not permutations
// of one city set. a stalled receiver holds the block in its emit step; the
// output register lets the next position be prepared meanwhile.
// the block takes the next tour once the final result is in the output register.
// reset (synchronous, active high) empties the load counter and the output.
module pmx_permutation_crossover_top import pmx_pkg::*; #(
  parameter int TOUR_LEN_MAX = TOUR_LEN_MAX_DEF,
  parameter int CITY_BITS    = CITY_BITS_DEF,
  localparam int IDX_W       = $clog2(TOUR_LEN_MAX)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CITY_BITS-1:0] gene_a,
  input  logic [CITY_BITS-1:0] gene_b,
  input  logic [CUT_BITS-1:0]  cut_left,
  input  logic [CUT_BITS-1:0]  cut_right,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     position,
  output logic [CITY_BITS-1:0] child_a,
  output logic [CITY_BITS-1:0] child_b,
  output logic                 bad_parents,
  output logic                 last_out
);

  pmx_cmd_t cmd;
  pmx_sts_t sts;

  pmx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (last),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pmx_datapath #(
    .TOUR_LEN_MAX (TOUR_LEN_MAX),
    .CITY_BITS    (CITY_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .gene_a      (gene_a),
    .gene_b      (gene_b),
    .cut_left    (cut_left),
    .cut_right   (cut_right),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .position    (position),
    .child_a     (child_a),
    .child_b     (child_b),
    .bad_parents (bad_parents),
    .last_out    (last_out)
  );

endmodule
